// ===== rtl/core/vrm_pkg.sv =====
// ----------------------------------------------------------------------------
// vrm_pkg
// shared types, constants and helpers of the vector rotate/magnitude unit
// ----------------------------------------------------------------------------
package vrm_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int XW       = 42;
    localparam int ZW       = 34;
    localparam int GUARD    = 8;
    localparam int PS_SHIFT = 30 - GUARD;

    localparam logic signed [31:0] GAIN_Q30     = 32'sd652032874;
    localparam logic        [63:0] TURN_PER_RAD = 64'h28BE_60DB_9391_054A;
    localparam logic        [63:0] TURN_PER_DEG = 64'd51240955760304310;
    localparam logic signed [65:0] PI_K         = 66'sd3373259426;
    localparam logic signed [65:0] DEG_K        = 66'sd360;

    localparam logic [29:0] ATAN_TURNS [32] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
        30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
    };

    typedef enum logic [2:0] {
        CMD_ADD     = 3'd0,
        CMD_SUB     = 3'd1,
        CMD_SCALE   = 3'd2,
        CMD_ROT_RAD = 3'd3,
        CMD_ROT_DEG = 3'd4,
        CMD_VEC_RAD = 3'd5,
        CMD_VEC_DEG = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_PASS = 2'd0,
        MODE_ROT  = 2'd1,
        MODE_VEC  = 2'd2,
        MODE_AXIS = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic               deg;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic               ov;
    } t_side;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_vec;

    // {overflow, saturated value}
    function automatic logic [32:0] sat32(input logic signed [65:0] v);
        logic [32:0] r;
        if (v > 66'sd2147483647) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -66'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/vrm_pre.sv =====
// ----------------------------------------------------------------------------
// vrm_pre
// front stages: add/sub/scale, angle to turns, quadrant fold, gain prescale
// ----------------------------------------------------------------------------
module vrm_pre #(
    parameter int FRAC_BITS = vrm_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [2:0]          i_cmd,
    input  logic signed [31:0]  i_ax,
    input  logic signed [31:0]  i_ay,
    input  logic signed [31:0]  i_bx,
    input  logic signed [31:0]  i_by,
    input  logic signed [31:0]  i_sa,
    output logic                o_valid,
    output vrm_pkg::t_side      o_side,
    output vrm_pkg::t_vec       o_vec
);
    import vrm_pkg::*;

    localparam int                 TurnSh = 32 + FRAC_BITS;
    localparam logic        [95:0] TurnRnd = 96'd1 << (TurnSh - 1);
    localparam logic signed [64:0] ScRnd = 65'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] PsRnd = 64'sd1 <<< (PS_SHIFT - 1);

    // stage 1
    logic               r1_valid;
    logic [2:0]         r1_cmd;
    logic signed [31:0] r1_ax, r1_ay;
    logic signed [32:0] r1_sx, r1_sy;
    logic signed [63:0] r1_px, r1_py;
    logic        [63:0] r1_lo, r1_hi;
    logic               r1_neg;

    logic        [31:0] n1_mag;
    logic        [63:0] n1_k;

    always_comb begin
        n1_mag = i_sa[31] ? 32'(-i_sa) : 32'(i_sa);
        n1_k   = (t_cmd'(i_cmd) == CMD_ROT_RAD) ? TURN_PER_RAD : TURN_PER_DEG;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
        if (i_en) begin
            r1_cmd <= i_cmd;
            r1_ax  <= i_ax;
            r1_ay  <= i_ay;
            r1_sx  <= (t_cmd'(i_cmd) == CMD_ADD) ? 33'(i_ax) + 33'(i_bx)
                                                 : 33'(i_ax) - 33'(i_bx);
            r1_sy  <= (t_cmd'(i_cmd) == CMD_ADD) ? 33'(i_ay) + 33'(i_by)
                                                 : 33'(i_ay) - 33'(i_by);
            r1_px  <= 64'(i_ax) * 64'(i_sa);
            r1_py  <= 64'(i_ay) * 64'(i_sa);
            r1_lo  <= 64'(n1_mag) * 64'(n1_k[31:0]);
            r1_hi  <= 64'(n1_mag) * 64'(n1_k[63:32]);
            r1_neg <= i_sa[31];
        end
    end

    // stage 2
    logic               r2_valid;
    t_side              r2_side;
    logic signed [31:0] r2_ax, r2_ay;
    logic signed [ZW-1:0] r2_z;
    logic               r2_neg;

    logic        [95:0] n2_p;
    logic        [95:0] n2_tt;
    logic        [31:0] n2_t, n2_q;
    logic signed [64:0] n2_scx, n2_scy;
    logic        [32:0] n2_a, n2_b;
    t_side              n2_side;

    always_comb begin
        n2_p   = (96'(r1_hi) << 32) + 96'(r1_lo) + TurnRnd;
        n2_tt  = n2_p >> TurnSh;
        n2_t   = r1_neg ? 32'(-n2_tt[31:0]) : n2_tt[31:0];
        n2_q   = n2_t + 32'h4000_0000;
        n2_scx = (65'(r1_px) + ScRnd) >>> FRAC_BITS;
        n2_scy = (65'(r1_py) + ScRnd) >>> FRAC_BITS;
        n2_a   = 33'd0;
        n2_b   = 33'd0;
        n2_side = '{mode: MODE_PASS, deg: 1'b0, rx: 32'sd0, ry: 32'sd0, ov: 1'b0};
        case (t_cmd'(r1_cmd))
            CMD_ADD, CMD_SUB: begin
                n2_a = sat32(66'(r1_sx));
                n2_b = sat32(66'(r1_sy));
            end
            CMD_SCALE: begin
                n2_a = sat32(66'(n2_scx));
                n2_b = sat32(66'(n2_scy));
            end
            CMD_ROT_RAD, CMD_ROT_DEG: n2_side.mode = MODE_ROT;
            CMD_VEC_RAD: n2_side.mode = MODE_VEC;
            CMD_VEC_DEG: begin
                n2_side.mode = MODE_VEC;
                n2_side.deg  = 1'b1;
            end
            default: n2_side.mode = MODE_PASS;
        endcase
        n2_side.rx = n2_a[31:0];
        n2_side.ry = n2_b[31:0];
        n2_side.ov = n2_a[32] | n2_b[32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            r2_side <= n2_side;
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_neg  <= n2_q[31];
            r2_z    <= ZW'(signed'(n2_q[31] ? (n2_t ^ 32'h8000_0000) : n2_t));
        end
    end

    // stage 3
    logic               r3_valid;
    t_side              r3_side;
    logic signed [63:0] r3_px, r3_py;
    logic signed [ZW-1:0] r3_z;
    logic               r3_spec;
    logic        [31:0] r3_smag;

    logic               n3_vneg, n3_spec;
    logic        [31:0] n3_smag, n3_absx, n3_absy;
    logic signed [ZW-1:0] n3_z;
    logic signed [32:0] n3_vx, n3_vy;
    t_side              n3_side;

    always_comb begin
        n3_absx = r2_ax[31] ? 32'(-r2_ax) : 32'(r2_ax);
        n3_absy = r2_ay[31] ? 32'(-r2_ay) : 32'(r2_ay);
        n3_vneg = 1'b0;
        n3_spec = 1'b0;
        n3_smag = 32'd0;
        n3_z    = r2_z;
        n3_side = r2_side;
        if (r2_side.mode == MODE_ROT) begin
            n3_vneg = r2_neg;
        end else if (r2_side.mode == MODE_VEC) begin
            if (r2_ax == 32'sd0 && r2_ay == 32'sd0) begin
                n3_spec = 1'b1;
                n3_z    = '0;
            end else if (r2_ay == 32'sd0) begin
                n3_spec = 1'b1;
                n3_smag = n3_absx;
                n3_z    = r2_ax[31] ? ZW'(34'sd2147483648) : ZW'(34'sd0);
            end else if (r2_ax == 32'sd0) begin
                n3_spec = 1'b1;
                n3_smag = n3_absy;
                n3_z    = r2_ay[31] ? ZW'(-34'sd1073741824) : ZW'(34'sd1073741824);
            end else begin
                n3_vneg = r2_ax[31];
                n3_z    = r2_ax[31] ? ZW'(34'sd2147483648) : ZW'(34'sd0);
            end
        end
        // axis and zero vectors bypass the micro-rotations
        if (n3_spec) begin
            n3_side.mode = MODE_AXIS;
        end
        n3_vx = n3_vneg ? -33'(r2_ax) : 33'(r2_ax);
        n3_vy = n3_vneg ? -33'(r2_ay) : 33'(r2_ay);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
        if (i_en) begin
            r3_side <= n3_side;
            r3_px   <= 64'(n3_vx) * 64'(GAIN_Q30);
            r3_py   <= 64'(n3_vy) * 64'(GAIN_Q30);
            r3_z    <= n3_z;
            r3_spec <= n3_spec;
            r3_smag <= n3_smag;
        end
    end

    // stage 4
    logic               r4_valid;
    t_side              r4_side;
    t_vec               r4_vec;

    logic signed [63:0] n4_x, n4_y;
    t_vec               n4_vec;

    always_comb begin
        n4_x = (r3_px + PsRnd) >>> PS_SHIFT;
        n4_y = (r3_py + PsRnd) >>> PS_SHIFT;
        if (r3_spec) begin
            n4_vec.x = XW'({1'b0, r3_smag}) <<< GUARD;
            n4_vec.y = '0;
        end else begin
            n4_vec.x = XW'(n4_x);
            n4_vec.y = XW'(n4_y);
        end
        n4_vec.z = r3_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= r3_valid;
        end
        if (i_en) begin
            r4_side <= r3_side;
            r4_vec  <= n4_vec;
        end
    end

    assign o_valid = r4_valid;
    assign o_side  = r4_side;
    assign o_vec   = r4_vec;

endmodule

// ===== rtl/core/vrm_cstage.sv =====
// ----------------------------------------------------------------------------
// vrm_cstage
// one registered cordic micro-rotation, rotation or vectoring per transaction
// ----------------------------------------------------------------------------
module vrm_cstage #(
    parameter int STEP = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  vrm_pkg::t_side  i_side,
    input  vrm_pkg::t_vec   i_vec,
    output logic            o_valid,
    output vrm_pkg::t_side  o_side,
    output vrm_pkg::t_vec   o_vec
);
    import vrm_pkg::*;

    logic                 r_valid;
    t_side                r_side;
    t_vec                 r_vec;

    logic signed [XW-1:0] n_dx, n_dy;
    logic signed [ZW-1:0] n_a;
    logic                 n_dir;
    t_vec                 n_vec;

    always_comb begin
        n_dx  = i_vec.y >>> STEP;
        n_dy  = i_vec.x >>> STEP;
        n_a   = ZW'(ATAN_TURNS[STEP % 32]);
        n_dir = (i_side.mode == MODE_ROT) ? !i_vec.z[ZW-1] : i_vec.y[XW-1];
        n_vec = i_vec;
        if (i_side.mode inside {MODE_ROT, MODE_VEC}) begin
            if (n_dir) begin
                n_vec.x = i_vec.x - n_dx;
                n_vec.y = i_vec.y + n_dy;
                n_vec.z = i_vec.z - n_a;
            end else begin
                n_vec.x = i_vec.x + n_dx;
                n_vec.y = i_vec.y - n_dy;
                n_vec.z = i_vec.z + n_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_side <= i_side;
            r_vec  <= n_vec;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_vec   = r_vec;

endmodule

// ===== rtl/core/vrm_post.sv =====
// ----------------------------------------------------------------------------
// vrm_post
// back stages: output rounding, saturation, turns to radians or degrees
// ----------------------------------------------------------------------------
module vrm_post #(
    parameter int FRAC_BITS = vrm_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  vrm_pkg::t_side     i_side,
    input  vrm_pkg::t_vec      i_vec,
    output logic               o_valid,
    output logic signed [31:0] o_rx,
    output logic signed [31:0] o_ry,
    output logic        [30:0] o_magnitude,
    output logic signed [31:0] o_angle,
    output logic               o_overflow
);
    import vrm_pkg::*;

    localparam int                   DegSh  = 32 - FRAC_BITS;
    localparam int                   RadSh  = 61 - FRAC_BITS;
    localparam logic signed [65:0]   DegRnd = 66'sd1 <<< (DegSh - 1);
    localparam logic signed [65:0]   RadRnd = 66'sd1 <<< (RadSh - 1);
    localparam logic signed [XW-1:0] XRnd   = XW'(1) <<< (GUARD - 1);
    localparam logic signed [XW-1:0] MagMax = XW'(64'sd2147483647);

    // stage 1
    logic               r1_valid;
    logic               r1_vecm, r1_deg, r1_ov;
    logic signed [31:0] r1_rx, r1_ry;
    logic        [30:0] r1_mag;
    logic signed [65:0] r1_prod;

    logic signed [XW-1:0] n1_xr, n1_yr;
    logic        [32:0] n1_a, n1_b;
    logic signed [32:0] n1_zf;
    logic signed [31:0] n1_rx, n1_ry;
    logic        [30:0] n1_mag;
    logic               n1_ov;

    always_comb begin
        n1_xr  = (i_vec.x + XRnd) >>> GUARD;
        n1_yr  = (i_vec.y + XRnd) >>> GUARD;
        n1_a   = sat32(66'(n1_xr));
        n1_b   = sat32(66'(n1_yr));
        n1_zf  = (i_vec.z[31:0] == 32'h8000_0000) ? 33'sd2147483648
                                                  : 33'(signed'(i_vec.z[31:0]));
        n1_rx  = i_side.rx;
        n1_ry  = i_side.ry;
        n1_ov  = i_side.ov;
        n1_mag = 31'd0;
        case (i_side.mode)
            MODE_ROT: begin
                n1_rx = n1_a[31:0];
                n1_ry = n1_b[31:0];
                n1_ov = n1_a[32] | n1_b[32];
            end
            MODE_VEC, MODE_AXIS: begin
                n1_rx = 32'sd0;
                n1_ry = 32'sd0;
                n1_ov = 1'b0;
                if (n1_xr > MagMax) begin
                    n1_mag = 31'h7FFF_FFFF;
                    n1_ov  = 1'b1;
                end else if (n1_xr[XW-1]) begin
                    n1_mag = 31'd0;
                end else begin
                    n1_mag = n1_xr[30:0];
                end
            end
            default: begin
                n1_mag = 31'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
        if (i_en) begin
            r1_vecm <= (i_side.mode inside {MODE_VEC, MODE_AXIS});
            r1_deg  <= i_side.deg;
            r1_ov   <= n1_ov;
            r1_rx   <= n1_rx;
            r1_ry   <= n1_ry;
            r1_mag  <= n1_mag;
            r1_prod <= 66'(n1_zf) * (i_side.deg ? DEG_K : PI_K);
        end
    end

    // stage 2, output register
    logic               r2_valid;
    logic signed [31:0] r2_rx, r2_ry, r2_ang;
    logic        [30:0] r2_mag;
    logic               r2_ov;

    logic signed [65:0] n2_deg, n2_rad;
    logic        [32:0] n2_s;

    always_comb begin
        n2_deg = (r1_prod + DegRnd) >>> DegSh;
        n2_rad = (r1_prod + RadRnd) >>> RadSh;
        n2_s   = sat32(r1_deg ? n2_deg : n2_rad);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            r2_rx  <= r1_rx;
            r2_ry  <= r1_ry;
            r2_mag <= r1_mag;
            r2_ang <= r1_vecm ? n2_s[31:0] : 32'sd0;
            r2_ov  <= r1_ov | (r1_vecm & n2_s[32]);
        end
    end

    assign o_valid     = r2_valid;
    assign o_rx        = r2_rx;
    assign o_ry        = r2_ry;
    assign o_magnitude = r2_mag;
    assign o_angle     = r2_ang;
    assign o_overflow  = r2_ov;

endmodule

// ===== rtl/core/vector2d_rotate_magnitude_angle_unit.sv =====
// ----------------------------------------------------------------------------
// vector2d_rotate_magnitude_angle_unit
// pipelined q16.16 vector add/sub/scale, cordic rotate and magnitude/angle
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_stall  | i_cmd i_ax i_ay i_bx i_by i_scale_or_angle
//  output  | out       | o_valid / i_stall  | o_rx o_ry o_magnitude o_angle o_overflow
//
//  one transaction enters per cycle while o_stall is low; the pipeline has
//  four front stages, one stage per cordic step and two back stages
//  the whole pipeline advances together; it holds only while the output
//  register is full and i_stall is high
//  i_rst_n is synchronous and clears all valid bits
// ----------------------------------------------------------------------------
module vector2d_rotate_magnitude_angle_unit #(
    parameter int CORDIC_STEPS = vrm_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = vrm_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_cmd,
    input  logic signed [31:0] i_ax,
    input  logic signed [31:0] i_ay,
    input  logic signed [31:0] i_bx,
    input  logic signed [31:0] i_by,
    input  logic signed [31:0] i_scale_or_angle,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_rx,
    output logic signed [31:0] o_ry,
    output logic        [30:0] o_magnitude,
    output logic signed [31:0] o_angle,
    output logic               o_overflow
);
    import vrm_pkg::*;

    logic  en;
    logic  valid_w [CORDIC_STEPS+1];
    t_side side_w  [CORDIC_STEPS+1];
    t_vec  vec_w   [CORDIC_STEPS+1];

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    vrm_pre #(
        .FRAC_BITS (FRAC_BITS)
    ) u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .i_ax    (i_ax),
        .i_ay    (i_ay),
        .i_bx    (i_bx),
        .i_by    (i_by),
        .i_sa    (i_scale_or_angle),
        .o_valid (valid_w[0]),
        .o_side  (side_w[0]),
        .o_vec   (vec_w[0])
    );

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
        vrm_cstage #(
            .STEP (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (valid_w[g]),
            .i_side  (side_w[g]),
            .i_vec   (vec_w[g]),
            .o_valid (valid_w[g+1]),
            .o_side  (side_w[g+1]),
            .o_vec   (vec_w[g+1])
        );
    end

    vrm_post #(
        .FRAC_BITS (FRAC_BITS)
    ) u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (valid_w[CORDIC_STEPS]),
        .i_side      (side_w[CORDIC_STEPS]),
        .i_vec       (vec_w[CORDIC_STEPS]),
        .o_valid     (o_valid),
        .o_rx        (o_rx),
        .o_ry        (o_ry),
        .o_magnitude (o_magnitude),
        .o_angle     (o_angle),
        .o_overflow  (o_overflow)
    );

endmodule
